### rtl/rrsm_pkg.sv
// Shared types, widths and helpers for the round robin schedule metrics unit.
`timescale 1ns / 1ps
`default_nettype none

package rrsm_pkg;

  localparam int VAL_W  = 16;
  localparam int TIME_W = 20;
  localparam int POS_W  = 4;

  // One stored process: load data plus round robin bookkeeping
  typedef struct packed {
    logic [VAL_W-1:0]  arrival;
    logic [VAL_W-1:0]  burst;
    logic [VAL_W-1:0]  rem;
    logic              done;
    logic [TIME_W-1:0] completion;
  } proc_rec_t;

  // Result of one round robin turn from the shared turn unit
  typedef struct packed {
    logic              finish;
    logic [VAL_W-1:0]  rem_next;
    logic [TIME_W-1:0] time_next;
  } turn_res_t;

  // Absolute difference of two time values
  function automatic logic [TIME_W-1:0] abs_diff(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

`default_nettype wire

### rtl/rrsm_proc_ram.sv
// Process record memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module rrsm_proc_ram
  import rrsm_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire proc_rec_t                wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output proc_rec_t                     rdata
);

  proc_rec_t mem [DEPTH];

  // Write on enable, read every cycle through a register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/rrsm_turn_unit.sv
// Shared turn unit: grants one time slice to one process.
`timescale 1ns / 1ps
`default_nettype none

module rrsm_turn_unit
  import rrsm_pkg::*;
(
  input  wire logic [VAL_W-1:0]  rem,
  input  wire logic [TIME_W-1:0] elapsed,
  input  wire logic [VAL_W-1:0]  q,
  output turn_res_t              res
);

  logic [VAL_W-1:0] slice;

  // Finish when the remaining time fits in one quantum
  always_comb begin
    res.finish    = (rem <= q);
    slice         = res.finish ? rem : q;
    res.rem_next  = rem - slice;
    res.time_next = elapsed + {{(TIME_W-VAL_W){1'b0}}, slice};
  end

endmodule

`default_nettype wire

### rtl/round_robin_schedule_metrics_unit.sv
// Top level: loads a process set, schedules it round robin, emits per-process metrics.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | in_valid / in_ready    | arrival, burst, last
//  out      | out_valid / out_ready  | position, arrival_out, burst_out, completion,
//           |                        | turnaround, waiting, final_res
//  cfg      | cfg_we (no wait)       | cfg_wdata -> quantum
//
// Load: an item is inserted in arrival order as it arrives, shifting each stored
//   entry with a later arrival up one slot through the record RAM.
// Run: turn slots go through the shared turn unit; a pass visits all n entries,
//   finished ones included; the run ends at the slot where the last process finishes.
// Output: each result is read from the record RAM, its turnaround registered, and
//   then presented; a stall on out_ready holds it.
// Reset clears control state only; the record RAM needs no clearing pass.
// in_ready is high whenever the unit is idle, between items as well as between sets;
//   a held result does not block the next load.
`timescale 1ns / 1ps
`default_nettype none

module round_robin_schedule_metrics_unit
  import rrsm_pkg::*;
#(
  parameter int MAX_PROCS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [VAL_W-1:0]  cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [VAL_W-1:0]  arrival,
  input  wire logic [VAL_W-1:0]  burst,
  input  wire logic              last,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [POS_W-1:0]       position,
  output logic [VAL_W-1:0]       arrival_out,
  output logic [VAL_W-1:0]       burst_out,
  output logic [TIME_W-1:0]      completion,
  output logic [TIME_W-1:0]      turnaround,
  output logic [TIME_W-1:0]      waiting,
  output logic                   final_res
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INS_RD  = 9'b000000010,
    S_INS_CMP = 9'b000000100,
    S_INS_PUT = 9'b000001000,
    S_RUN_RD  = 9'b000010000,
    S_RUN_EX  = 9'b000100000,
    S_OUT_RD  = 9'b001000000,
    S_OUT_TAT = 9'b010000000,
    S_OUT_WT  = 9'b100000000
  } state_t;

  state_t            state;
  logic [VAL_W-1:0]  quantum;
  logic [VAL_W-1:0]  q_eff;
  logic [CW-1:0]     count;
  logic [CW-1:0]     nproc;
  logic [CW-1:0]     fin_cnt;
  logic [AW-1:0]     ins_pos;
  logic [AW-1:0]     idx;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] tat;
  logic [VAL_W-1:0]  hold_arr;
  logic [VAL_W-1:0]  hold_bur;
  logic              hold_last;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  proc_rec_t         ram_wdata;
  logic [AW-1:0]     ram_raddr;
  proc_rec_t         ram_rdata;
  proc_rec_t         new_rec;
  turn_res_t         turn;
  logic              shift_up;
  logic              out_free;
  logic              last_idx;
  logic              all_done;

  assign in_ready = (state == S_IDLE);
  assign q_eff    = (quantum == '0) ? VAL_W'(1) : quantum;
  assign shift_up = (ram_rdata.arrival > hold_arr);
  assign out_free = !out_valid || out_ready;
  assign last_idx = (idx == AW'(nproc - CW'(1)));
  assign all_done = ((fin_cnt + CW'(turn.finish)) == nproc);

  // Hold the quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= VAL_W'(1);
    end else if (cfg_we) begin
      quantum <= cfg_wdata;
    end
  end

  rrsm_proc_ram #(
    .DEPTH (MAX_PROCS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrsm_turn_unit u_turn (
    .rem     (ram_rdata.rem),
    .elapsed (elapsed),
    .q       (q_eff),
    .res     (turn)
  );

  // Build the record of the item being inserted
  always_comb begin
    new_rec.arrival    = hold_arr;
    new_rec.burst      = hold_bur;
    new_rec.rem        = hold_bur;
    new_rec.done       = 1'b0;
    new_rec.completion = '0;
  end

  // Steer the record RAM ports
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ins_pos;
    ram_wdata = new_rec;
    ram_raddr = (state == S_INS_RD) ? (ins_pos - AW'(1)) : idx;
    case (state)
      S_INS_CMP: begin
        ram_we    = shift_up;
        ram_wdata = ram_rdata;
      end
      S_INS_PUT: begin
        ram_we = 1'b1;
      end
      S_RUN_EX: begin
        ram_we         = !ram_rdata.done;
        ram_waddr      = idx;
        ram_wdata      = ram_rdata;
        ram_wdata.rem  = turn.rem_next;
        ram_wdata.done = turn.finish;
        if (turn.finish) begin
          ram_wdata.completion = turn.time_next;
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Raise the result valid on a new transfer, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT_WT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Sequence load, insertion, round robin turns and result output
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            hold_arr  <= arrival;
            hold_bur  <= burst;
            hold_last <= last;
            if (count < CW'(MAX_PROCS)) begin
              ins_pos <= count[AW-1:0];
              state   <= (count == '0) ? S_INS_PUT : S_INS_RD;
            end else if (last) begin
              // Full set: drop the item but compute what is held
              nproc   <= count;
              count   <= '0;
              idx     <= '0;
              fin_cnt <= '0;
              elapsed <= '0;
              state   <= S_RUN_RD;
            end
          end
        end
        S_INS_RD: begin
          state <= S_INS_CMP;
        end
        S_INS_CMP: begin
          if (shift_up) begin
            ins_pos <= ins_pos - AW'(1);
            state   <= (ins_pos == AW'(1)) ? S_INS_PUT : S_INS_RD;
          end else begin
            state <= S_INS_PUT;
          end
        end
        S_INS_PUT: begin
          if (hold_last) begin
            nproc   <= count + CW'(1);
            count   <= '0;
            idx     <= '0;
            fin_cnt <= '0;
            elapsed <= '0;
            state   <= S_RUN_RD;
          end else begin
            count <= count + CW'(1);
            state <= S_IDLE;
          end
        end
        S_RUN_RD: begin
          state <= S_RUN_EX;
        end
        S_RUN_EX: begin
          if (!ram_rdata.done) begin
            elapsed <= turn.time_next;
            if (turn.finish) begin
              fin_cnt <= fin_cnt + CW'(1);
            end
          end
          if (!ram_rdata.done && all_done) begin
            idx   <= '0;
            state <= S_OUT_RD;
          end else begin
            idx   <= last_idx ? '0 : (idx + AW'(1));
            state <= S_RUN_RD;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_TAT;
        end
        S_OUT_TAT: begin
          tat   <= abs_diff(ram_rdata.completion, TIME_W'(ram_rdata.arrival));
          state <= S_OUT_WT;
        end
        S_OUT_WT: begin
          if (out_free) begin
            position    <= POS_W'(idx);
            arrival_out <= ram_rdata.arrival;
            burst_out   <= ram_rdata.burst;
            completion  <= ram_rdata.completion;
            turnaround  <= tat;
            waiting     <= abs_diff(tat, TIME_W'(ram_rdata.burst));
            final_res   <= last_idx;
            if (last_idx) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_OUT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Never hold more entries than the store has
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_PROCS))
    else $error("loaded count exceeds capacity");

  // Every turn slot sees at least one unfinished process
  a_run_open: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN_RD || state == S_RUN_EX) |-> (fin_cnt < nproc))
    else $error("run continues with all processes finished");

  // A shift compare always has an entry below the insert point
  a_ins_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_CMP) |-> (ins_pos != '0))
    else $error("insert compare at position zero");

  // A stalled result holds the sequencer in the output state
  a_out_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT_WT && out_valid && !out_ready) |=> (state == S_OUT_WT))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire
